// ===== rtl/core/obb_overlap_penetration_test_macros.svh =====
// Assertion macros used by the back end of the oriented-box overlap test.
`ifndef OBB_OVERLAP_PENETRATION_TEST_MACROS_SVH
`define OBB_OVERLAP_PENETRATION_TEST_MACROS_SVH

// Property checked at every clock edge outside reset.
`define OBB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define OBB_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/obb_pkg.sv =====
// Types and constants shared by the oriented-box overlap test.
package obb_pkg;

    localparam logic [2:0] OP_CENTER = 3'd0;
    localparam logic [2:0] OP_AXIS0  = 3'd1;
    localparam logic [2:0] OP_AXIS1  = 3'd2;
    localparam logic [2:0] OP_AXIS2  = 3'd3;
    localparam logic [2:0] OP_HALF   = 3'd4;

    localparam int NUM_ROWS = 10;
    localparam logic [3:0] BOX_ROWS  = 4'd5;
    localparam logic [3:0] ROW_C0    = 4'd0;
    localparam logic [3:0] ROW_C1    = 4'd5;
    localparam logic [3:0] ROW_HALF  = 4'd4;

    localparam logic [3:0]  LAST_AXIS = 4'd14;
    localparam logic [3:0]  NO_AXIS   = 4'd15;
    localparam logic [30:0] PEN_MAX   = 31'h7FFF_FFFF;
    localparam logic [31:0] THR_RESET = 32'd429497;

    typedef struct packed {
        logic [2:0]         op;
        logic               box_select;
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic        overlap;
        logic [30:0] min_penetration;
        logic [3:0]  best_axis;
    } out_item_t;

    typedef struct packed {
        logic               wr;
        logic               last;
        logic [3:0]         row;
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
    } q_entry_t;

endpackage

// ===== rtl/core/obb_overlap_penetration_test.sv =====
// Oriented-box overlap test by separating axes: top level.
// Usage:
//  item channel (item_valid/item_ready/item) loads one vector per item into
//  a ten-row store: center, three axes and half sizes of box 0 or box 1.
//  An item with last set runs the test over 15 axes once its vector is stored.
//  result channel (result_valid/result_ready/result) carries one item per
//  last item: overlap flag, smallest penetration and its axis index.
//  cfg_we/cfg_wdata write the degenerate-axis threshold; write only when idle.
// Operation:
//  load items pass a two-entry queue and are popped by the back end when idle.
//  the test runs on one shared multiplier with a registered product;
//  degenerate axes, whose squared length is below the threshold, are skipped;
//  a separating axis ends the test early.
//  further items queue while the test runs, up to two, then item_ready drops.
// Reset: queue empty, no result pending, threshold back to its default.
//  The vector store is not cleared; load both boxes before the first test.
// Stall: the result is held in an output register until taken; a new result
//  waits for it, and the queue keeps accepting until full.
module obb_overlap_penetration_test
    import obb_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        item_valid,
    output logic        item_ready,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_ready,
    output out_item_t   result
);

    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    obb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_entry    (q_entry)
    );

    obb_back #(
        .VW (VALUE_WIDTH),
        .FB (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (q_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/core/obb_front.sv =====
// Front end: accepts load items, classifies them and queues them for the back end.
module obb_front
    import obb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output logic     q_valid,
    input  logic     q_pop,
    output q_entry_t q_entry
);

    localparam int DEPTH = 2;

    q_entry_t   fifo_reg [DEPTH];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    q_entry_t   entry;
    logic       push;

    always_comb
    begin
        entry.wr     = item.op inside {[OP_CENTER:OP_HALF]};
        entry.last   = item.last;
        entry.row    = (item.box_select ? BOX_ROWS : 4'd0) + {1'b0, item.op};
        entry.comp_x = item.comp_x;
        entry.comp_y = item.comp_y;
        entry.comp_z = item.comp_z;
    end

    assign item_ready = (cnt_reg != 2'(DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_entry    = fifo_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = q_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/obb_back.sv =====
// Back end: vector store, shared multiplier and the separating-axis sequencer.
`include "obb_overlap_penetration_test_macros.svh"
module obb_back
    import obb_pkg::*;
#(
    parameter int VW = 32,
    parameter int FB = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        q_valid,
    output logic        q_pop,
    input  q_entry_t    q_entry,
    output logic        result_valid,
    input  logic        result_ready,
    output out_item_t   result
);

    localparam int W   = VW + 4;
    localparam int W2  = 2 * VW;
    localparam int SQW = 2 * VW + 2;
    localparam logic signed [W-1:0]  VMAX_W = W'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [W-1:0]  VMIN_W = -VMAX_W - W'(1);
    localparam logic signed [W2-1:0] VMAX_2 = W2'(VMAX_W);
    localparam logic signed [W2-1:0] VMIN_2 = W2'(VMIN_W);
    localparam logic signed [63:0]   VMAX_64 = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [63:0]   VMIN_64 = -VMAX_64 - 64'sd1;

    typedef logic signed [VW-1:0] val_t;
    typedef logic [2:0][VW-1:0]   row_t;

    typedef enum logic [24:0] {
        S_IDLE = 25'h0000001, S_TC_A = 25'h0000002, S_TC_B = 25'h0000004,
        S_TC_C = 25'h0000008, S_AX_A = 25'h0000010, S_AX_B = 25'h0000020,
        S_LD_A = 25'h0000040, S_LD_B = 25'h0000080, S_LD_C = 25'h0000100,
        S_CR_M = 25'h0000200, S_CR_C = 25'h0000400, S_SQ_M = 25'h0000800,
        S_SQ_A = 25'h0001000, S_DEG  = 25'h0002000, S_PD_A = 25'h0004000,
        S_PD_M = 25'h0008000, S_PD_C = 25'h0010000, S_PH_A = 25'h0020000,
        S_PH_M = 25'h0040000, S_PH_C = 25'h0080000, S_TD_M = 25'h0100000,
        S_TD_C = 25'h0200000, S_PEN  = 25'h0400000, S_NEXT = 25'h0800000,
        S_DONE = 25'h1000000
    } state_t;

    function automatic val_t sat(input logic signed [W-1:0] v);
        if (v > VMAX_W)
            return VMAX_W[VW-1:0];
        else if (v < VMIN_W)
            return VMIN_W[VW-1:0];
        return v[VW-1:0];
    endfunction

    function automatic val_t sat_in(input logic signed [31:0] x);
        logic signed [63:0] v;
        v = 64'(x);
        if (v > VMAX_64)
            return VMAX_64[VW-1:0];
        else if (v < VMIN_64)
            return VMIN_64[VW-1:0];
        return v[VW-1:0];
    endfunction

    function automatic val_t sat_abs(input logic signed [W-1:0] v);
        val_t s;
        s = sat(v);
        return (s < 0) ? sat(-W'(s)) : s;
    endfunction

    function automatic val_t mulq(input logic signed [W2-1:0] p);
        logic signed [W2-1:0] sh;
        sh = p >>> FB;
        if (sh > VMAX_2)
            return VMAX_W[VW-1:0];
        else if (sh < VMIN_2)
            return VMIN_W[VW-1:0];
        return sh[VW-1:0];
    endfunction

    // operand picks for the cross product terms, {a index, b index}
    function automatic logic [3:0] cross_sel(input logic [2:0] s);
        case (s)
            3'd0:    return {2'd1, 2'd2};
            3'd1:    return {2'd2, 2'd1};
            3'd2:    return {2'd2, 2'd0};
            3'd3:    return {2'd0, 2'd2};
            3'd4:    return {2'd0, 2'd1};
            3'd5:    return {2'd1, 2'd0};
            default: return 4'd0;
        endcase
    endfunction

    row_t mem [NUM_ROWS];
    row_t rd_row_reg;
    logic [3:0] rd_addr;
    logic wr_en;

    state_t state_reg, state_next;
    logic [3:0] n_reg, n_next;
    logic [1:0] ai_reg, ai_next, aj_reg, aj_next;
    logic [1:0] k_reg, k_next, j_reg, j_next;
    logic [2:0] s_reg, s_next;
    logic b_reg, b_next;
    val_t ax_reg [3], ax_next [3];
    val_t tc_reg [3], tc_next [3];
    val_t ua_reg [3], ua_next [3];
    val_t ub_reg [3], ub_next [3];
    val_t tmp_reg, tmp_next;
    logic signed [W2-1:0] prod_reg, prod_next;
    logic [SQW-1:0] sq_reg, sq_next;
    logic signed [W-1:0] dacc_reg, dacc_next, pacc_reg, pacc_next, psum_reg, psum_next;
    logic signed [W-1:0] pacc_sum;
    val_t best_reg, best_next, pen;
    logic [3:0] idx_reg, idx_next;
    logic found_reg, found_next, sep_reg, sep_next;
    logic [31:0] thr_reg;
    logic res_valid_reg, res_valid_next;
    out_item_t res_reg, res_next;
    val_t mul_a, mul_b, mq, dabs;
    logic [3:0] sel;
    logic [63:0] best_w;

    assign mq       = mulq(prod_reg);
    assign dabs     = sat_abs(dacc_reg);
    assign sel      = cross_sel(s_reg);
    assign best_w   = 64'(best_reg);
    assign pacc_sum = pacc_reg + W'(mq);
    assign pen      = sat(psum_reg - W'(dabs));

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;  ai_next = ai_reg;  aj_next = aj_reg;
        k_next = k_reg;  j_next = j_reg;  s_next = s_reg;  b_next = b_reg;
        ax_next = ax_reg;  tc_next = tc_reg;  ua_next = ua_reg;  ub_next = ub_reg;
        tmp_next = tmp_reg;  sq_next = sq_reg;
        dacc_next = dacc_reg;  pacc_next = pacc_reg;  psum_next = psum_reg;
        best_next = best_reg;  idx_next = idx_reg;
        found_next = found_reg;  sep_next = sep_reg;
        res_valid_next = res_valid_reg;  res_next = res_reg;
        wr_en = 1'b0;  q_pop = 1'b0;  rd_addr = ROW_C0;
        mul_a = '0;  mul_b = '0;

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    wr_en = q_entry.wr;
                    if (q_entry.last)
                    begin
                        n_next = 4'd0;  ai_next = 2'd0;  aj_next = 2'd0;
                        found_next = 1'b0;  sep_next = 1'b0;
                        best_next = '0;  idx_next = NO_AXIS;
                        state_next = S_TC_A;
                    end
                end
            end
            S_TC_A:
            begin
                rd_addr = ROW_C0;
                state_next = S_TC_B;
            end
            S_TC_B:
            begin
                rd_addr = ROW_C1;
                for (int c = 0; c < 3; c++)
                    ua_next[c] = $signed(rd_row_reg[c]);
                state_next = S_TC_C;
            end
            S_TC_C:
            begin
                for (int c = 0; c < 3; c++)
                    tc_next[c] = sat(W'($signed(rd_row_reg[c])) - W'(ua_reg[c]));
                state_next = S_AX_A;
            end
            S_AX_A:
            begin
                rd_addr = ((n_reg >= 4'd3) ? BOX_ROWS : 4'd0) + 4'd1 + 4'(ai_reg);
                state_next = S_AX_B;
            end
            S_AX_B:
            begin
                for (int c = 0; c < 3; c++)
                    ax_next[c] = $signed(rd_row_reg[c]);
                k_next = 2'd0;  sq_next = '0;
                state_next = S_SQ_M;
            end
            S_LD_A:
            begin
                rd_addr = 4'd1 + 4'(ai_reg);
                state_next = S_LD_B;
            end
            S_LD_B:
            begin
                rd_addr = BOX_ROWS + 4'd1 + 4'(aj_reg);
                for (int c = 0; c < 3; c++)
                    ua_next[c] = $signed(rd_row_reg[c]);
                state_next = S_LD_C;
            end
            S_LD_C:
            begin
                for (int c = 0; c < 3; c++)
                    ub_next[c] = $signed(rd_row_reg[c]);
                s_next = 3'd0;
                state_next = S_CR_M;
            end
            S_CR_M:
            begin
                mul_a = ua_reg[sel[3:2]];
                mul_b = ub_reg[sel[1:0]];
                state_next = S_CR_C;
            end
            S_CR_C:
            begin
                if (!s_reg[0])
                    tmp_next = mq;
                else
                    ax_next[s_reg[2:1]] = sat(W'(tmp_reg) - W'(mq));
                if (s_reg == 3'd5)
                begin
                    k_next = 2'd0;  sq_next = '0;
                    state_next = S_SQ_M;
                end
                else
                begin
                    s_next = s_reg + 3'd1;
                    state_next = S_CR_M;
                end
            end
            S_SQ_M:
            begin
                mul_a = ax_reg[k_reg];
                mul_b = ax_reg[k_reg];
                state_next = S_SQ_A;
            end
            S_SQ_A:
            begin
                sq_next = sq_reg + SQW'(prod_reg);
                if (k_reg == 2'd2)
                    state_next = S_DEG;
                else
                begin
                    k_next = k_reg + 2'd1;
                    state_next = S_SQ_M;
                end
            end
            S_DEG:
            begin
                if (sq_reg < SQW'(thr_reg))
                    state_next = S_NEXT;
                else
                begin
                    b_next = 1'b0;  k_next = 2'd0;  j_next = 2'd0;
                    dacc_next = '0;  pacc_next = '0;  psum_next = '0;
                    state_next = S_PD_A;
                end
            end
            S_PD_A, S_PD_M, S_PD_C:
            begin
                rd_addr = (b_reg ? BOX_ROWS : 4'd0) + 4'd1 + 4'(k_reg);
                if (state_reg == S_PD_A)
                    state_next = S_PD_M;
                else if (state_reg == S_PD_M)
                begin
                    mul_a = ax_reg[j_reg];
                    mul_b = $signed(rd_row_reg[j_reg]);
                    state_next = S_PD_C;
                end
                else
                begin
                    dacc_next = dacc_reg + W'(mq);
                    if (j_reg == 2'd2)
                    begin
                        j_next = 2'd0;
                        state_next = S_PH_A;
                    end
                    else
                    begin
                        j_next = j_reg + 2'd1;
                        state_next = S_PD_M;
                    end
                end
            end
            S_PH_A:
            begin
                rd_addr = (b_reg ? BOX_ROWS : 4'd0) + ROW_HALF;
                state_next = S_PH_M;
            end
            S_PH_M:
            begin
                rd_addr = (b_reg ? BOX_ROWS : 4'd0) + ROW_HALF;
                mul_a = $signed(rd_row_reg[k_reg]);
                mul_b = dabs;
                state_next = S_PH_C;
            end
            S_PH_C:
            begin
                dacc_next = '0;
                if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    psum_next = psum_reg + W'(sat(pacc_sum));
                    pacc_next = '0;
                    if (b_reg)
                    begin
                        j_next = 2'd0;
                        state_next = S_TD_M;
                    end
                    else
                    begin
                        b_next = 1'b1;
                        state_next = S_PD_A;
                    end
                end
                else
                begin
                    pacc_next = pacc_sum;
                    k_next = k_reg + 2'd1;
                    state_next = S_PD_A;
                end
            end
            S_TD_M:
            begin
                mul_a = tc_reg[j_reg];
                mul_b = ax_reg[j_reg];
                state_next = S_TD_C;
            end
            S_TD_C:
            begin
                dacc_next = dacc_reg + W'(mq);
                if (j_reg == 2'd2)
                    state_next = S_PEN;
                else
                begin
                    j_next = j_reg + 2'd1;
                    state_next = S_TD_M;
                end
            end
            S_PEN:
            begin
                if (pen < 0)
                begin
                    sep_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    if (!found_reg || pen < best_reg)
                    begin
                        best_next = pen;
                        idx_next = n_reg;
                        found_next = 1'b1;
                    end
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (n_reg == LAST_AXIS)
                    state_next = S_DONE;
                else
                begin
                    n_next = n_reg + 4'd1;
                    if (n_reg < 4'd5)
                    begin
                        ai_next = (ai_reg == 2'd2) ? 2'd0 : ai_reg + 2'd1;
                        state_next = S_AX_A;
                    end
                    else
                    begin
                        if (n_reg == 4'd5)
                        begin
                            ai_next = 2'd0;
                            aj_next = 2'd0;
                        end
                        else if (aj_reg == 2'd2)
                        begin
                            aj_next = 2'd0;
                            ai_next = ai_reg + 2'd1;
                        end
                        else
                            aj_next = aj_reg + 2'd1;
                        state_next = S_LD_A;
                    end
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next = 1'b1;
                    if (sep_reg)
                        res_next = '{overlap: 1'b0, min_penetration: '0, best_axis: '0};
                    else if (!found_reg)
                        res_next = '{overlap: 1'b1, min_penetration: PEN_MAX,
                                     best_axis: NO_AXIS};
                    else
                        res_next = '{overlap: 1'b1,
                                     min_penetration: (best_w > 64'(PEN_MAX)) ?
                                                      PEN_MAX : best_w[30:0],
                                     best_axis: idx_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign prod_next = W2'(mul_a) * W2'(mul_b);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[q_entry.row] <= {sat_in(q_entry.comp_z), sat_in(q_entry.comp_y),
                                 sat_in(q_entry.comp_x)};
        end
        rd_row_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;  ai_reg <= ai_next;  aj_reg <= aj_next;
        s_reg <= s_next;  b_reg <= b_next;
        ax_reg <= ax_next;  tc_reg <= tc_next;  ua_reg <= ua_next;  ub_reg <= ub_next;
        tmp_reg <= tmp_next;  prod_reg <= prod_next;  sq_reg <= sq_next;
        dacc_reg <= dacc_next;  pacc_reg <= pacc_next;  psum_reg <= psum_next;
        best_reg <= best_next;  idx_reg <= idx_next;
        found_reg <= found_next;  sep_reg <= sep_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            j_reg         <= 2'd0;
            thr_reg       <= THR_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
                thr_reg <= cfg_wdata;
        end
    end

    `OBB_ASSERT(a_state_onehot, $onehot(state_reg), "sequencer state not one-hot")
    `OBB_ASSERT(a_res_from_done, $rose(res_valid_reg) |-> $past(state_reg) == S_DONE, "result raised outside done state")
    `OBB_NEVER(a_pop_busy, q_pop && state_reg != S_IDLE, "queue popped while test runs")
    `OBB_NEVER(a_counter_range, k_reg == 2'd3 || j_reg == 2'd3, "component counter out of range")

endmodule

// ===== test/tb.sv =====
// Testbench for the oriented-box overlap test: random box pairs checked against a fixed-point predictor.
`timescale 1ns / 100ps

module tb
    import obb_pkg::*;
();

    typedef logic signed [63:0] q_t;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 12000000;

    class overlap_board;
        q_t store [30];
        logic [31:0] thr;
        out_item_t pending [$];
        int errors;

        function new();
            thr = THR_RESET;
            errors = 0;
            foreach (store[i]) store[i] = 0;
        endfunction

        function q_t sat(q_t v);
            if (v > VMAX) return VMAX;
            if (v < VMIN) return VMIN;
            return v;
        endfunction

        function q_t sabs(q_t v);
            return v < 0 ? sat(-v) : v;
        endfunction

        function q_t mulq(q_t a, q_t b);
            logic signed [127:0] p;
            p = 128'(a) * 128'(b);
            p = p >>> 16;
            if (p > 128'(VMAX)) return VMAX;
            if (p < 128'(VMIN)) return VMIN;
            return q_t'(p);
        endfunction

        function q_t dot(q_t u [3], q_t v [3]);
            return sat(mulq(u[0], v[0]) + mulq(u[1], v[1]) + mulq(u[2], v[2]));
        endfunction

        function q_t proj(int base, q_t ax [3]);
            q_t s;
            q_t v [3];
            s = 0;
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 3; c++) v[c] = store[base + 3 + 3 * k + c];
                s += mulq(store[base + 12 + k], sabs(dot(ax, v)));
            end
            return sat(s);
        endfunction

        function bit degenerate(q_t ax [3]);
            logic [127:0] sum;
            logic [127:0] sq;
            sum = 0;
            for (int k = 0; k < 3; k++)
            begin
                sq = 128'(ax[k] < 0 ? -ax[k] : ax[k]);
                sq = sq * sq;
                if (sq >= 128'(thr)) return 0;
                sum += sq;
            end
            return sum < 128'(thr);
        endfunction

        function void note_item(in_item_t it);
            q_t axes [15][3];
            q_t tc [3];
            q_t pen, best;
            bit found, sep;
            int bidx;
            out_item_t r;
            if (it.op <= OP_HALF)
            begin
                store[it.box_select * 15 + it.op * 3]     = it.comp_x;
                store[it.box_select * 15 + it.op * 3 + 1] = it.comp_y;
                store[it.box_select * 15 + it.op * 3 + 2] = it.comp_z;
            end
            if (!it.last) return;
            for (int k = 0; k < 3; k++) tc[k] = sat(store[15 + k] - store[k]);
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                begin
                    axes[i][k] = store[3 + 3 * i + k];
                    axes[3 + i][k] = store[18 + 3 * i + k];
                end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    axes[6 + 3 * i + j][0] = sat(mulq(axes[i][1], axes[3 + j][2])
                                               - mulq(axes[i][2], axes[3 + j][1]));
                    axes[6 + 3 * i + j][1] = sat(mulq(axes[i][2], axes[3 + j][0])
                                               - mulq(axes[i][0], axes[3 + j][2]));
                    axes[6 + 3 * i + j][2] = sat(mulq(axes[i][0], axes[3 + j][1])
                                               - mulq(axes[i][1], axes[3 + j][0]));
                end
            found = 0;
            sep = 0;
            best = 0;
            bidx = NO_AXIS;
            for (int n = 0; n < 15; n++)
            begin
                if (degenerate(axes[n])) continue;
                pen = sat(proj(0, axes[n]) + proj(15, axes[n]) - sabs(dot(tc, axes[n])));
                if (pen < 0)
                begin
                    sep = 1;
                    break;
                end
                if (!found || pen < best)
                begin
                    best = pen;
                    bidx = n;
                    found = 1;
                end
            end
            if (sep) r = '0;
            else if (!found) r = '{1'b1, PEN_MAX, NO_AXIS};
            else r = '{1'b1, best[30:0], bidx[3:0]};
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.overlap !== e.overlap)
            begin
                $display("%0t overlap exp %0d got %0d", $time, e.overlap, got.overlap);
                errors++;
            end
            if (got.min_penetration !== e.min_penetration)
            begin
                $display("%0t min_penetration exp %0d got %0d", $time,
                         e.min_penetration, got.min_penetration);
                errors++;
            end
            if (got.best_axis !== e.best_axis)
            begin
                $display("%0t best_axis exp %0d got %0d", $time, e.best_axis, got.best_axis);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;
    logic item_valid;
    logic item_ready;
    in_item_t item;
    logic result_valid;
    logic result_ready;
    out_item_t result;

    overlap_board board;
    int send_idle;
    int recv_idle;
    int hold_off;
    int cycles;

    obb_overlap_penetration_test dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready) board.check_result(result);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                result_ready <= 0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function logic [31:0] rand_comp(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
            default:
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    task automatic send(logic [2:0] op, logic bs, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, logic lst);
        in_item_t it;
        it = '{op, bs, x, y, z, lst};
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 0;
            @(posedge clk);
        end
        item_valid <= 1;
        item <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        board.note_item(it);
    endtask

    task automatic send_box(logic bs, int kind, logic lst);
        for (int op = 0; op <= 4; op++)
            send(op[2:0], bs, rand_comp(kind), rand_comp(kind), rand_comp(kind),
                 lst && op == 4);
    endtask

    task automatic drain();
        item_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
    endtask

    task automatic set_thr(logic [31:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        board.thr = v;
    endtask

    task automatic random_pairs(int n);
        int kind;
        for (int p = 0; p < n; p++)
        begin
            kind = $urandom_range(9) < 6 ? ($urandom_range(1) ? 1 : 2)
                                         : ($urandom_range(1) ? 0 : 3);
            if ($urandom_range(9) == 0)
                send(3'($urandom_range(5, 7)), 1'($urandom()), $urandom(), $urandom(),
                     $urandom(), 1'($urandom_range(1)));
            else if ($urandom_range(9) == 0)
                send(3'($urandom_range(4)), 1'($urandom()), rand_comp(kind),
                     rand_comp(kind), rand_comp(kind), 1'($urandom_range(1)));
            else
            begin
                send_box(0, kind, 0);
                send_box(1, kind, 1);
            end
        end
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        hold_off = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        item_valid = 0;
        item = '0;
        result_ready = 0;
        send_idle = 33;
        recv_idle = 86;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: aligned unit boxes, touching, separated, extremes, degenerate
        send(OP_CENTER, 0, 0, 0, 0, 0);
        send(OP_AXIS0, 0, 32'h10000, 0, 0, 0);
        send(OP_AXIS1, 0, 0, 32'h10000, 0, 0);
        send(OP_AXIS2, 0, 0, 0, 32'h10000, 0);
        send(OP_HALF, 0, 32'h10000, 32'h10000, 32'h10000, 0);
        send(OP_CENTER, 1, 32'h18000, 0, 0, 0);
        send(OP_AXIS0, 1, 32'h10000, 0, 0, 0);
        send(OP_AXIS1, 1, 0, 32'h10000, 0, 0);
        send(OP_AXIS2, 1, 0, 0, 32'h10000, 0);
        send(OP_HALF, 1, 32'h10000, 32'h10000, 32'h10000, 1);
        send(OP_CENTER, 1, 32'h20000, 0, 0, 1);
        send(OP_CENTER, 1, 32'h30000, 0, 0, 1);
        send(OP_HALF, 1, 32'hFFFF0000, 32'h10000, 32'h10000, 1);
        send(3'd7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send(OP_AXIS0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send(OP_CENTER, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        set_thr(32'hFFFF_FFFF);
        send(OP_AXIS0, 0, 32'h1, 0, 0, 1);
        set_thr(32'h0);
        send(OP_AXIS1, 0, 0, 0, 0, 1);
        set_thr(THR_RESET);
        random_pairs(30);

        // receiver holds off while the sender keeps offering
        hold_off = 4000;
        random_pairs(4);
        drain();
        random_pairs(40);
        set_thr(32'h00FF_FFFF);
        random_pairs(40);

        send_idle = 86;
        recv_idle = 33;
        set_thr(32'd0);
        random_pairs(40);
        set_thr($urandom());
        random_pairs(20);

        send_idle = 0;
        recv_idle = 0;
        set_thr(THR_RESET);
        random_pairs(25);

        drain();
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
